// ===== hdl/ftw_pkg.sv =====
// Shared types, constants and helpers for the four-level page table walker.
package ftw_pkg;

  localparam int unsigned VA_W     = 48;
  localparam int unsigned PA_W     = 64;
  localparam int unsigned IDX_W    = 9;
  localparam int unsigned PAGE_W   = 4;
  localparam int unsigned FRAME_W  = 40;
  localparam int unsigned LEVEL_W  = 2;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [0:0] OP_TRANSLATE = 1'b0;
  localparam logic [0:0] OP_WRITE     = 1'b1;

  // Register index taken from paddr[2]
  localparam logic [0:0] REG_ROOT_TABLE_PAGE = 1'b0;

  localparam int unsigned PTE_PRESENT_BIT = 0;
  localparam int unsigned PTE_PS_BIT      = 7;
  localparam int unsigned PTE_FRAME_LSB   = 12;

  localparam logic [LEVEL_W-1:0] LEVEL_TOP = 2'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_4K  = 2'd0;
  localparam logic [PA_W-1:0]    ALL_ONES  = '1;

  typedef struct packed {
    logic [0:0]          opcode;
    logic [VA_W-1:0]     virtual_address;
    logic [PAGE_W-1:0]   write_page;
    logic [IDX_W-1:0]    write_index;
    logic [PA_W-1:0]     write_value;
  } ftw_req_t;

  typedef struct packed {
    logic [PA_W-1:0]     physical_address;
    logic                found;
    logic [LEVEL_W-1:0]  page_level;
  } ftw_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;     // write one zero entry of the clearing pass
    logic accept;    // input word taken this cycle
    logic step;      // descend one level, issue the next table read
    logic out_load;  // load the result register
  } ftw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic is_translate;
    logic walk_done;
  } ftw_sts_t;

  // Offset mask for a page mapped at the given level: 2^(12+9*level)-1
  function automatic logic [PA_W-1:0] page_mask(input logic [LEVEL_W-1:0] level);
    logic [PA_W-1:0] m;
    unique case (level)
      2'd0:    m = 64'h0000_0000_0000_0fff;
      2'd1:    m = 64'h0000_0000_001f_ffff;
      2'd2:    m = 64'h0000_0000_3fff_ffff;
      default: m = 64'h0000_007f_ffff_ffff;
    endcase
    return m;
  endfunction

  // 9-bit table index of the virtual address for the given level
  function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                 input logic [LEVEL_W-1:0] level);
    logic [IDX_W-1:0] idx;
    unique case (level)
      2'd0:    idx = va[20:12];
      2'd1:    idx = va[29:21];
      2'd2:    idx = va[38:30];
      default: idx = va[47:39];
    endcase
    return idx;
  endfunction

endpackage

// ===== hdl/ftw_ram.sv =====
// Generic single-port RAM with registered read data.
module ftw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ftw_ctrl.sv =====
// Walk controller: clearing pass, input acceptance, walk sequencing, result handshake.
module ftw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  ftw_pkg::ftw_sts_t sts_i,
  output ftw_pkg::ftw_cmd_t cmd_o
);
  import ftw_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.is_translate) begin
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (sts_i.walk_done) begin
          // hold the finished entry in the RAM read register until the result slot frees
          if (out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/ftw_dp.sv =====
// Walk datapath: table memory, root register, level and address registers, result register.
module ftw_dp #(
  parameter int unsigned TABLE_PAGES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ftw_pkg::ftw_cmd_t               cmd_i,
  output ftw_pkg::ftw_sts_t               sts_o,
  input  ftw_pkg::ftw_req_t               in_data_i,
  output ftw_pkg::ftw_rsp_t               out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ftw_pkg::PADDR_W-1:0]     paddr,
  input  logic [ftw_pkg::PDATA_W-1:0]     pwdata,
  output logic [ftw_pkg::PDATA_W-1:0]     prdata
);
  import ftw_pkg::*;

  localparam int unsigned Depth = TABLE_PAGES * (1 << IDX_W);
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned PageW = $clog2(TABLE_PAGES);
  localparam logic [FRAME_W-1:0] NumPages = FRAME_W'(TABLE_PAGES);
  localparam logic [AddrW-1:0]   LastAddr = AddrW'(Depth - 1);

  logic [PAGE_W-1:0]  root_q;
  logic [VA_W-1:0]    vaddr_q;
  logic [LEVEL_W-1:0] level_q;
  logic               walk_ok_q;
  logic [AddrW-1:0]   clr_cnt_q;
  ftw_rsp_t           rsp_q;

  logic [FRAME_W-1:0] root_ext, wpage_ext, frame;
  logic               root_ok, wpage_ok, frame_bad;
  logic               is_write, present, page_size, leaf, ok;
  logic [LEVEL_W-1:0] level_next;
  logic [PA_W-1:0]    entry, mask;
  logic               ram_we, ram_re;
  logic [AddrW-1:0]   ram_addr;
  logic [PA_W-1:0]    ram_wdata;
  logic [PA_W-1:0]    ram_rdata_w;
  ftw_rsp_t           rsp_d;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_ROOT_TABLE_PAGE) begin
      root_q <= pwdata[PAGE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ROOT_TABLE_PAGE) ?
                  {{(PDATA_W-PAGE_W){1'b0}}, root_q} : '0;

  assign root_ext  = {{(FRAME_W-PAGE_W){1'b0}}, root_q};
  assign wpage_ext = {{(FRAME_W-PAGE_W){1'b0}}, in_data_i.write_page};
  assign root_ok   = root_ext < NumPages;
  assign wpage_ok  = wpage_ext < NumPages;
  assign is_write  = in_data_i.opcode == OP_WRITE;

  // Entry just read
  assign entry      = ram_rdata_w;
  assign present    = entry[PTE_PRESENT_BIT];
  assign page_size  = entry[PTE_PS_BIT];
  assign frame      = entry[51:PTE_FRAME_LSB];
  assign frame_bad  = frame >= NumPages;
  assign leaf       = (level_q == LEVEL_4K) || page_size;
  assign ok         = walk_ok_q && present && leaf;
  assign level_next = level_q - 2'd1;

  assign sts_o.clear_last   = clr_cnt_q == LastAddr;
  assign sts_o.is_translate = in_data_i.opcode == OP_TRANSLATE;
  assign sts_o.walk_done    = !walk_ok_q || !present || leaf || frame_bad;

  // Table memory port
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = clr_cnt_q;
    ram_wdata = '0;
    priority if (cmd_i.clear) begin
      ram_we = 1'b1;
    end else if (cmd_i.accept && is_write) begin
      ram_we    = wpage_ok;
      ram_addr  = {wpage_ext[PageW-1:0], in_data_i.write_index};
      ram_wdata = in_data_i.write_value;
    end else if (cmd_i.accept) begin
      ram_re   = root_ok;
      ram_addr = {root_ext[PageW-1:0], va_index(in_data_i.virtual_address, LEVEL_TOP)};
    end else if (cmd_i.step) begin
      ram_re   = 1'b1;
      ram_addr = {frame[PageW-1:0], va_index(vaddr_q, level_next)};
    end
  end

  ftw_ram #(
    .WIDTH (PA_W),
    .DEPTH (Depth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !is_write) begin
      vaddr_q   <= in_data_i.virtual_address;
      level_q   <= LEVEL_TOP;
      walk_ok_q <= root_ok;
    end else if (cmd_i.step) begin
      level_q <= level_next;
    end
  end

  // Result formation
  assign mask = page_mask(level_q);

  always_comb begin
    rsp_d.page_level = level_q;
    if (ok) begin
      rsp_d.physical_address = (entry & ~mask) | ({{(PA_W-VA_W){1'b0}}, vaddr_q} & mask);
      rsp_d.found            = 1'b1;
    end else begin
      rsp_d.physical_address = ALL_ONES;
      rsp_d.found            = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_data_o = rsp_q;

endmodule

// ===== hdl/four_level_page_table_walker.sv =====
// Four-level page table walker: top level.
// Translates 48-bit virtual addresses through a four-level table held in an
// internal table memory of TABLE_PAGES pages of 512 64-bit entries. A translate
// word is accepted and issues the root read, then visits 1 to 4 table levels,
// each set by the registered read of the single-port table memory; the walk
// cannot issue the next read before the previous entry returns. A write word is
// taken without a walk, returns nothing and frees the input for the next word.
// A finished result sits in an output register, and the next word is accepted
// while it waits. After reset the block clears all TABLE_PAGES*512 entries of the
// table memory (8192 by default), one entry per cycle; in_stall_o stays high
// during that pass, while configuration writes are taken at any time.
module four_level_page_table_walker #(
  parameter int unsigned TABLE_PAGES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ftw_pkg::ftw_req_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ftw_pkg::ftw_rsp_t           out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ftw_pkg::PADDR_W-1:0] paddr,
  input  logic [ftw_pkg::PDATA_W-1:0] pwdata,
  output logic [ftw_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import ftw_pkg::*;

  ftw_cmd_t cmd;
  ftw_sts_t sts;

  assign pready = 1'b1;

  ftw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ftw_dp #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata)
  );

endmodule

// ===== hdl/ftw_chk.sv =====
// Port-level checks for the page table walker, bound to the top level.
module ftw_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input ftw_pkg::ftw_req_t           in_data_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input ftw_pkg::ftw_rsp_t           out_data_o
);
  import ftw_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // A fault always carries the all-ones address
  a_fault_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.physical_address == ALL_ONES)
    else $error("fault without all-ones address");

  // A translation keeps the input stalled in the cycle after its acceptance
  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.opcode == OP_TRANSLATE |=> in_stall_o)
    else $error("input taken right after a translate word");

  // A table write never produces a result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.opcode == OP_WRITE && !out_valid_o |=> !out_valid_o)
    else $error("result appeared after a table write");

endmodule

bind four_level_page_table_walker ftw_chk u_ftw_chk (.*);

// ===== tb/four_level_page_table_walker_tb.sv =====
// Self-checking testbench for the four-level page table walker.
module four_level_page_table_walker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ftw_pkg::*;

  localparam int unsigned TABLE_PAGES = 16;
  localparam int unsigned ENTRIES     = 512;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          LONG_HOLD   = 300;
  localparam int          WRITE_SETTLE = 8;
  localparam int          DIR_ROWS    = 24;
  localparam int          PHASES      = 6;
  localparam int          PHASE_WORDS = 155;

  localparam logic [PADDR_W-1:0] ROOT_ADDR = {REG_ROOT_TABLE_PAGE, 2'b00};

  localparam ftw_rsp_t NO_RSP   = '0;
  localparam ftw_rsp_t FAULT_L3 = {ALL_ONES, 1'b0, LEVEL_TOP};
  localparam ftw_rsp_t FAULT_L2 = {ALL_ONES, 1'b0, 2'd2};
  localparam ftw_rsp_t FAULT_L0 = {ALL_ONES, 1'b0, LEVEL_4K};

  typedef enum logic {FROM_PREDICTOR, FROM_TABLE} exp_src_e;

  typedef struct {
    logic [0:0]  op;
    logic [47:0] va;
    logic [3:0]  page;
    logic [8:0]  index;
    logic [63:0] value;
    exp_src_e    src;
    ftw_rsp_t    want;
  } dir_row_t;

  // Root page is 0 throughout this table.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_TRANSLATE, 48'h0000_0000_0000, 4'd0,  9'd0,   64'h0, FROM_TABLE, FAULT_L3},
    '{OP_TRANSLATE, 48'hFFFF_FFFF_FFFF, 4'd0,  9'd0,   64'h0, FROM_TABLE, FAULT_L3},
    // chain 0 -> 1 -> 2 -> 3 at index 0
    '{OP_WRITE, 48'h0, 4'd0, 9'd0, 64'h0000_0000_0000_1003, FROM_PREDICTOR, NO_RSP},
    '{OP_WRITE, 48'h0, 4'd1, 9'd0, 64'h0000_0000_0000_2001, FROM_PREDICTOR, NO_RSP},
    '{OP_WRITE, 48'h0, 4'd2, 9'd0, 64'h0000_0000_0000_3001, FROM_PREDICTOR, NO_RSP},
    '{OP_WRITE, 48'h0, 4'd3, 9'd0, 64'hFFF0_0000_ABCD_E001, FROM_PREDICTOR, NO_RSP},
    '{OP_TRANSLATE, 48'h0000_0000_0FFF, 4'd0, 9'd0, 64'h0, FROM_PREDICTOR, NO_RSP},
    // 4KiB entry not present
    '{OP_WRITE, 48'h0, 4'd3, 9'd1, 64'h0000_0000_1234_5000, FROM_PREDICTOR, NO_RSP},
    '{OP_TRANSLATE, 48'h0000_0000_1000, 4'd0, 9'd0, 64'h0, FROM_TABLE, FAULT_L0},
    // 2MiB page
    '{OP_WRITE, 48'h0, 4'd2, 9'd1, 64'h000F_FFFF_FFE0_0081, FROM_PREDICTOR, NO_RSP},
    '{OP_TRANSLATE, 48'h0000_003F_FFFF, 4'd0, 9'd0, 64'h0, FROM_PREDICTOR, NO_RSP},
    // 1GiB page, high entry bits kept
    '{OP_WRITE, 48'h0, 4'd1, 9'd1, 64'hFFFF_FFFF_C000_0081, FROM_PREDICTOR, NO_RSP},
    '{OP_TRANSLATE, 48'h0000_7FFF_FFFF, 4'd0, 9'd0, 64'h0, FROM_PREDICTOR, NO_RSP},
    // page size at the top level: 512GiB
    '{OP_WRITE, 48'h0, 4'd0, 9'd511, 64'h8000_8000_0000_0081, FROM_PREDICTOR, NO_RSP},
    '{OP_TRANSLATE, 48'hFFFF_FFFF_FFFF, 4'd0, 9'd0, 64'h0, FROM_PREDICTOR, NO_RSP},
    // next table just past the end of memory
    '{OP_WRITE, 48'h0, 4'd0, 9'd2, 64'h0000_0000_0001_0001, FROM_PREDICTOR, NO_RSP},
    '{OP_TRANSLATE, 48'h0100_0000_0000, 4'd0, 9'd0, 64'h0, FROM_TABLE, FAULT_L3},
    // next table frame all ones
    '{OP_WRITE, 48'h0, 4'd0, 9'd3, 64'h000F_FFFF_FFFF_F001, FROM_PREDICTOR, NO_RSP},
    '{OP_TRANSLATE, 48'h0180_0000_0000, 4'd0, 9'd0, 64'h0, FROM_TABLE, FAULT_L3},
    // page size bit at level 0 is ignored
    '{OP_WRITE, 48'h0, 4'd3, 9'd2, 64'h0000_0000_0005_5081, FROM_PREDICTOR, NO_RSP},
    '{OP_TRANSLATE, 48'h0000_0000_2ABC, 4'd0, 9'd0, 64'h0, FROM_PREDICTOR, NO_RSP},
    '{OP_WRITE, 48'h0, 4'd15, 9'd511, 64'hFFFF_FFFF_FFFF_FFFF, FROM_PREDICTOR, NO_RSP},
    // everything but present at level 2
    '{OP_WRITE, 48'h0, 4'd1, 9'd2, 64'hFFFF_FFFF_FFFF_FFFE, FROM_PREDICTOR, NO_RSP},
    '{OP_TRANSLATE, 48'h0000_8000_0000, 4'd0, 9'd0, 64'h0, FROM_TABLE, FAULT_L2}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  ftw_req_t          in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  ftw_rsp_t          out_data_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic              pready;

  // Shadow of the walker's state
  logic [63:0] entry_mem [TABLE_PAGES*ENTRIES];
  logic [3:0]  root_page;
  ftw_rsp_t    pending_xlat [$];
  logic [47:0] mapped_va [$];

  bit send_back_to_back;
  bit take_back_to_back;
  bit hold_request;

  int cycle_count;
  int mismatches;
  int words_sent;
  int xlat_count;
  int fault_count;
  int table_writes;
  int root_settings;
  int level_hits [4];

  four_level_page_table_walker #(
    .TABLE_PAGES(TABLE_PAGES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d translations outstanding",
               cycle_count, pending_xlat.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = rand64();
    return r[47:0];
  endfunction

  function automatic ftw_req_t rand_word();
    ftw_req_t w;
    w.opcode          = 1'($urandom_range(0, 1));
    w.virtual_address = rand48();
    w.write_page      = 4'($urandom_range(0, 15));
    w.write_index     = 9'($urandom_range(0, 511));
    w.write_value     = rand64();
    return w;
  endfunction

  // Walk the shadow tables from the root down to a leaf or a fault
  function automatic ftw_rsp_t predict_translation(input logic [47:0] va);
    ftw_rsp_t    r;
    logic [63:0] e;
    logic [63:0] mask;
    int unsigned pg;
    int          lvl;
    bit          hit;
    bit          done;
    pg   = root_page;
    lvl  = 3;
    hit  = 1'b0;
    done = (pg >= TABLE_PAGES);
    e    = '0;
    while (!done) begin
      e = entry_mem[pg * ENTRIES + int'(va[12 + 9*lvl +: 9])];
      if (!e[PTE_PRESENT_BIT]) begin
        done = 1'b1;
      end else if (lvl == 0 || e[PTE_PS_BIT]) begin
        hit  = 1'b1;
        done = 1'b1;
      end else if (e[51:12] >= TABLE_PAGES) begin
        done = 1'b1;
      end else begin
        pg = int'(e[51:12]);
        lvl--;
      end
    end
    mask = (64'd1 << (12 + 9*lvl)) - 64'd1;
    r.physical_address = hit ? ((e & ~mask) | ({16'h0, va} & mask)) : ALL_ONES;
    r.found            = hit;
    r.page_level       = lvl[1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 30)
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(input ftw_rsp_t got);
    ftw_rsp_t want;
    if (pending_xlat.size() == 0) begin
      report_mismatch("result with nothing pending", got.physical_address, ALL_ONES);
      return;
    end
    want = pending_xlat.pop_front();
    if (got.physical_address !== want.physical_address)
      report_mismatch("physical_address", got.physical_address, want.physical_address);
    if (got.found !== want.found)
      report_mismatch("found", 64'(got.found), 64'(want.found));
    if (got.page_level !== want.page_level)
      report_mismatch("page_level", 64'(got.page_level), 64'(want.page_level));
  endtask

  // Offer one word, wait for it to be taken, then update the shadow state
  task automatic put_word(input ftw_req_t w, input exp_src_e src, input ftw_rsp_t typed);
    int       gap;
    ftw_rsp_t want;
    gap = send_back_to_back ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    words_sent++;
    if (w.opcode == OP_WRITE) begin
      if (w.write_page < TABLE_PAGES)
        entry_mem[int'(w.write_page) * ENTRIES + int'(w.write_index)] = w.write_value;
      table_writes++;
    end else begin
      want = (src == FROM_TABLE) ? typed : predict_translation(w.virtual_address);
      pending_xlat.push_back(want);
      xlat_count++;
      if (want.found) level_hits[want.page_level]++;
      else fault_count++;
    end
  endtask

  task automatic translate(input logic [47:0] va);
    ftw_req_t w;
    w = rand_word();
    w.opcode          = OP_TRANSLATE;
    w.virtual_address = va;
    put_word(w, FROM_PREDICTOR, NO_RSP);
  endtask

  task automatic write_entry(input logic [3:0] pg, input logic [8:0] idx,
                             input logic [63:0] value);
    ftw_req_t w;
    w = rand_word();
    w.opcode      = OP_WRITE;
    w.write_page  = pg;
    w.write_index = idx;
    w.write_value = value;
    put_word(w, FROM_PREDICTOR, NO_RSP);
  endtask

  // Lay down a path for a random address, then translate it and its neighbors.
  // A broken path ends early on a missing entry or a frame past the memory.
  task automatic walk_sequence(input bit broken);
    logic [47:0] va;
    logic [47:0] offs;
    logic [63:0] e;
    logic [63:0] far;
    logic [3:0]  pg;
    logic [3:0]  next_pg;
    int          leaf;
    int          brk;
    int          lvl;
    va   = rand48();
    pg   = root_page;
    leaf = $urandom_range(0, 3);
    brk  = broken ? $urandom_range(leaf, 3) : -1;
    for (lvl = 3; lvl >= leaf; lvl--) begin
      e       = rand64();
      next_pg = 4'($urandom_range(0, 15));
      if (lvl == brk) begin
        if ($urandom_range(0, 1) != 0) begin
          e[PTE_PRESENT_BIT] = 1'b0;
        end else begin
          far = rand64();
          e[PTE_PRESENT_BIT] = 1'b1;
          e[PTE_PS_BIT]      = 1'b0;
          e[51:12]           = far[39:0];
          if (e[51:16] == '0) e[16] = 1'b1;
        end
      end else if (lvl == leaf) begin
        e[PTE_PRESENT_BIT] = 1'b1;
        if (lvl != 0) e[PTE_PS_BIT] = 1'b1;
      end else begin
        e[PTE_PRESENT_BIT] = 1'b1;
        e[PTE_PS_BIT]      = 1'b0;
        e[51:12]           = {36'd0, next_pg};
      end
      write_entry(pg, va[12 + 9*lvl +: 9], e);
      if (lvl == brk) break;
      pg = next_pg;
    end
    mapped_va.push_back(va);
    if (mapped_va.size() > 64) void'(mapped_va.pop_front());
    offs = (48'd1 << (12 + 9*leaf)) - 48'd1;
    translate(va);
    repeat ($urandom_range(0, 2)) translate(va ^ (rand48() & offs));
  endtask

  // Hold the input back until every translation has come out
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_xlat.size() != 0);
    repeat (WRITE_SETTLE) @(posedge clk_i);
  endtask

  // Write root_table_page with junk in the upper bits, then read it back
  task automatic program_root(input logic [3:0] pg);
    logic [PDATA_W-1:0] wdata;
    logic [PDATA_W-1:0] rdata;
    wdata      = $urandom();
    wdata[3:0] = pg;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ROOT_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    root_page = pg;
    root_settings++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rdata !== {{(PDATA_W-4){1'b0}}, pg})
      report_mismatch("root_table_page readback", 64'(rdata), 64'(pg));
  endtask

  initial begin : result_side
    int stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        check_result(out_data_o);
        stall_left = take_back_to_back ? 0 : $urandom_range(0, 6);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    ftw_req_t   w;
    int         i;
    int         phase;
    int         phase_end;
    int         pick;
    bit         hold_sent;
    bit         pause_done;
    logic [3:0] root_sel;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    cycle_count = 0;
    mismatches  = 0;
    words_sent  = 0;
    hold_sent   = 1'b0;
    pause_done  = 1'b0;
    foreach (entry_mem[k]) entry_mem[k] = '0;
    foreach (level_hits[k]) level_hits[k] = 0;
    root_page = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The input stays stalled through the clearing pass after reset
    program_root(4'd0);
    for (i = 0; i < DIR_ROWS; i++) begin
      w                 = '0;
      w.opcode          = dir_rows[i].op;
      w.virtual_address = dir_rows[i].va;
      w.write_page      = dir_rows[i].page;
      w.write_index     = dir_rows[i].index;
      w.write_value     = dir_rows[i].value;
      put_word(w, dir_rows[i].src, dir_rows[i].want);
    end

    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      root_sel = (phase == 0) ? 4'd15 : (phase == 1) ? 4'd0 : 4'($urandom_range(0, 15));
      program_root(root_sel);
      send_back_to_back = (phase == 1 || phase == 2);
      take_back_to_back = (phase == 1);
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        // long output stall while words keep coming
        if (phase == 2 && !hold_sent && words_sent >= phase_end - 120) begin
          hold_request = 1'b1;
          hold_sent    = 1'b1;
        end
        if (phase == 3 && !pause_done && words_sent >= phase_end - 80) begin
          settle();
          pause_done = 1'b1;
        end
        pick = $urandom_range(0, 9);
        if (pick <= 5)
          walk_sequence(1'b0);
        else if (pick == 6)
          walk_sequence(1'b1);
        else if (pick == 7 && mapped_va.size() != 0)
          translate(mapped_va[$urandom_range(0, mapped_va.size() - 1)]);
        else if (pick == 8)
          write_entry(4'($urandom_range(0, 15)), 9'($urandom_range(0, 511)), rand64());
        else
          translate(rand48());
      end
    end

    settle();
    $display("%0d words sent over %0d root page settings: %0d table writes, %0d translations",
             words_sent, root_settings, table_writes, xlat_count);
    $display("translations: %0d faults, hits at 4KiB/2MiB/1GiB/512GiB %0d/%0d/%0d/%0d",
             fault_count, level_hits[0], level_hits[1], level_hits[2], level_hits[3]);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
